/* src/stmm_pkg.sv */
// stmm_pkg: shared types and constants of the sparse triple matrix multiplier
// no dependencies
`default_nettype none
package stmm_pkg;

    localparam int STMM_MAX_TERMS = 256;
    localparam int STMM_MAX_DIM   = 64;

    localparam int IDX_W   = 6;   // row and column fields of a triple
    localparam int VAL_W   = 32;
    localparam int TRIP_W  = 2 * IDX_W + VAL_W;
    localparam int DIMR_W  = 7;   // dimension registers
    localparam int CFG_A_W = 3;   // configuration index

    typedef enum logic [1:0] {
        REQ_LOAD_A = 2'd0,
        REQ_LOAD_B = 2'd1,
        REQ_FETCH  = 2'd2,
        REQ_CLEAR  = 2'd3
    } req_t;

    typedef enum logic [CFG_A_W-1:0] {
        CFG_A_ROWS = 3'd0,
        CFG_A_COLS = 3'd1,
        CFG_B_ROWS = 3'd2,
        CFG_B_COLS = 3'd3
    } cfg_idx_t;

    // control of the shared multiply-accumulate unit
    typedef struct packed {
        logic clear;
        logic mul_en;
        logic acc_en;
    } mac_ctrl_t;

endpackage
`default_nettype wire

/* src/stmm_if.sv */
// stmm_if: request, response and configuration channel interfaces
// depends on stmm_pkg
`default_nettype none
interface stmm_req_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        req_type;
    logic [stmm_pkg::IDX_W-1:0]        entry_row;
    logic [stmm_pkg::IDX_W-1:0]        entry_col;
    logic signed [stmm_pkg::VAL_W-1:0] entry_value;
    modport source (output valid, req_type, entry_row, entry_col, entry_value, input ready);
    modport sink   (input valid, req_type, entry_row, entry_col, entry_value, output ready);
endinterface

interface stmm_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [stmm_pkg::IDX_W-1:0]        out_row;
    logic [stmm_pkg::IDX_W-1:0]        out_col;
    logic signed [stmm_pkg::VAL_W-1:0] out_value;
    logic                              found;
    logic                              done_res;
    logic                              size_mismatch;
    logic                              table_overflow;
    modport source (output valid, out_row, out_col, out_value, found, done_res,
                    size_mismatch, table_overflow, input ready);
    modport sink   (input valid, out_row, out_col, out_value, found, done_res,
                    size_mismatch, table_overflow, output ready);
endinterface

interface stmm_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [stmm_pkg::CFG_A_W-1:0]       index;
    logic [stmm_pkg::DIMR_W-1:0]        data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* src/sparse_triple_matrix_multiply.sv */
// sparse_triple_matrix_multiply: loads, clear and a sequencer that scans both
// triple tables and feeds one shared multiply-accumulate unit
// depends on stmm_pkg, stmm_if, stmm_ram, stmm_mac
// load and clear respond in the next cycle; fetch visits each table entry in a read and a check state
// (S_A_RD/S_A_CHK, S_B_RD/S_B_CHK), per inner index scanning a then b, per position S_POS to S_PEND
// throughput: one item at a time, the next is taken once the result is taken
// the table entry scan through each table's single ram read port sets the fetch time
// reset: counts, cursor, dimension registers, response valid and flags cleared; tables undefined until loaded
`default_nettype none
module sparse_triple_matrix_multiply #(
    parameter int MAX_TERMS = stmm_pkg::STMM_MAX_TERMS,
    parameter int MAX_DIM   = stmm_pkg::STMM_MAX_DIM
) (
    input  wire logic clk,
    input  wire logic rst_n,
    stmm_req_if.sink   req,
    stmm_rsp_if.source rsp,
    stmm_cfg_if.sink   cfg
);
    import stmm_pkg::*;

    localparam int AW    = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CNT_W = $clog2(MAX_TERMS + 1);
    localparam int CW    = $clog2(MAX_DIM + 1);
    localparam int DW    = (CW > DIMR_W) ? CW : DIMR_W;
    localparam int IW    = (CW > IDX_W) ? CW : IDX_W;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_POS   = 10'b0000000010,
        S_KCHK  = 10'b0000000100,
        S_A_RD  = 10'b0000001000,
        S_A_CHK = 10'b0000010000,
        S_B_RD  = 10'b0000100000,
        S_B_CHK = 10'b0001000000,
        S_ACC   = 10'b0010000000,
        S_PEND  = 10'b0100000000,
        S_SPARE = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [DIMR_W-1:0] a_rows_reg, a_cols_reg, b_rows_reg, b_cols_reg;
    logic [CNT_W-1:0]  a_cnt_reg, a_cnt_next, b_cnt_reg, b_cnt_next;
    logic [CW-1:0]     cur_row_reg, cur_row_next, cur_col_reg, cur_col_next;
    logic [CW-1:0]     k_reg, k_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [VAL_W-1:0]  av_reg, av_next;

    logic              rsp_valid_reg, rsp_valid_next;
    logic [IDX_W-1:0]  rsp_row_reg, rsp_row_next, rsp_col_reg, rsp_col_next;
    logic [VAL_W-1:0]  rsp_val_reg, rsp_val_next;
    logic [3:0]        rsp_flags_reg, rsp_flags_next; // found, done, mismatch, overflow

    logic [CW-1:0]     rows, cols, inner;
    logic              a_we, b_we;
    logic [TRIP_W-1:0] wdata, a_rdata, b_rdata;
    logic [IDX_W-1:0]  rd_row, rd_col;
    logic [VAL_W-1:0]  a_val, b_val, acc;
    mac_ctrl_t         mac_ctrl;
    logic              accept;

    // dimension clamp
    function automatic logic [CW-1:0] clamp(input logic [DIMR_W-1:0] d);
        logic [DW-1:0] dx;
        dx = DW'(d);
        clamp = (dx > DW'(MAX_DIM)) ? CW'(MAX_DIM) : CW'(dx);
    endfunction

    assign rows  = clamp(a_rows_reg);
    assign cols  = clamp(b_cols_reg);
    assign inner = clamp(a_cols_reg);

    // configuration registers
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_rows_reg <= '0;
            a_cols_reg <= '0;
            b_rows_reg <= '0;
            b_cols_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_A_ROWS: a_rows_reg <= cfg.data;
                CFG_A_COLS: a_cols_reg <= cfg.data;
                CFG_B_ROWS: b_rows_reg <= cfg.data;
                CFG_B_COLS: b_cols_reg <= cfg.data;
                default:    ;
            endcase
        end
    end

    // triple tables
    assign wdata = {req.entry_row, req.entry_col, req.entry_value};

    stmm_ram #(.WIDTH(TRIP_W), .DEPTH(MAX_TERMS)) u_a_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_cnt_reg[AW-1:0]),
        .wdata (wdata),
        .raddr (idx_reg[AW-1:0]),
        .rdata (a_rdata)
    );

    stmm_ram #(.WIDTH(TRIP_W), .DEPTH(MAX_TERMS)) u_b_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_cnt_reg[AW-1:0]),
        .wdata (wdata),
        .raddr (idx_reg[AW-1:0]),
        .rdata (b_rdata)
    );

    assign a_val = a_rdata[VAL_W-1:0];
    assign b_val = b_rdata[VAL_W-1:0];

    // shared multiply-accumulate
    stmm_mac u_mac (
        .clk  (clk),
        .ctrl (mac_ctrl),
        .a    (av_reg),
        .b    (b_val),
        .acc  (acc)
    );

    assign req.ready = (state_reg == S_IDLE) && !rsp_valid_reg;
    assign accept    = req.valid && req.ready;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        a_cnt_next     = a_cnt_reg;
        b_cnt_next     = b_cnt_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        k_next         = k_reg;
        idx_next       = idx_reg;
        av_next        = av_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_row_next   = rsp_row_reg;
        rsp_col_next   = rsp_col_reg;
        rsp_val_next   = rsp_val_reg;
        rsp_flags_next = rsp_flags_reg;
        a_we           = 1'b0;
        b_we           = 1'b0;
        mac_ctrl       = '0;
        rd_row         = '0;
        rd_col         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_row_next   = '0;
                    rsp_col_next   = '0;
                    rsp_val_next   = '0;
                    rsp_flags_next = '0;
                    unique case (req.req_type)
                        REQ_LOAD_A:
                        begin
                            if (a_cnt_reg >= CNT_W'(MAX_TERMS))
                            begin
                                rsp_flags_next[0] = 1'b1;
                            end
                            else
                            begin
                                a_we       = 1'b1;
                                a_cnt_next = a_cnt_reg + 1'b1;
                            end
                        end
                        REQ_LOAD_B:
                        begin
                            if (b_cnt_reg >= CNT_W'(MAX_TERMS))
                            begin
                                rsp_flags_next[0] = 1'b1;
                            end
                            else
                            begin
                                b_we       = 1'b1;
                                b_cnt_next = b_cnt_reg + 1'b1;
                            end
                        end
                        REQ_FETCH:
                        begin
                            if (a_cols_reg != b_rows_reg)
                            begin
                                rsp_flags_next[1] = 1'b1;
                            end
                            else
                            begin
                                rsp_valid_next = 1'b0;
                                state_next     = S_POS;
                            end
                        end
                        default:
                        begin
                            a_cnt_next   = '0;
                            b_cnt_next   = '0;
                            cur_row_next = '0;
                            cur_col_next = '0;
                        end
                    endcase
                end
            end
            // next result position
            S_POS:
            begin
                if (cur_row_reg >= rows)
                begin
                    rsp_valid_next    = 1'b1;
                    rsp_flags_next[2] = 1'b1;
                    state_next        = S_IDLE;
                end
                else if (cur_col_reg >= cols)
                begin
                    cur_row_next = cur_row_reg + 1'b1;
                    cur_col_next = '0;
                end
                else
                begin
                    mac_ctrl.clear = 1'b1;
                    k_next         = '0;
                    state_next     = S_KCHK;
                end
            end
            // next inner index
            S_KCHK:
            begin
                idx_next = '0;
                if (k_reg >= inner)
                begin
                    state_next = S_PEND;
                end
                else
                begin
                    state_next = S_A_RD;
                end
            end
            // scan a for (row, k)
            S_A_RD:
            begin
                if (idx_reg >= a_cnt_reg)
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_KCHK;
                end
                else
                begin
                    state_next = S_A_CHK;
                end
            end
            S_A_CHK:
            begin
                rd_row = a_rdata[TRIP_W-1 -: IDX_W];
                rd_col = a_rdata[VAL_W +: IDX_W];
                if (IW'(rd_row) == IW'(cur_row_reg) && IW'(rd_col) == IW'(k_reg))
                begin
                    av_next    = a_val;
                    idx_next   = '0;
                    state_next = S_B_RD;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_A_RD;
                end
            end
            // scan b for (k, col)
            S_B_RD:
            begin
                if (idx_reg >= b_cnt_reg)
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_KCHK;
                end
                else
                begin
                    state_next = S_B_CHK;
                end
            end
            S_B_CHK:
            begin
                rd_row = b_rdata[TRIP_W-1 -: IDX_W];
                rd_col = b_rdata[VAL_W +: IDX_W];
                if (IW'(rd_row) == IW'(k_reg) && IW'(rd_col) == IW'(cur_col_reg))
                begin
                    mac_ctrl.mul_en = 1'b1;
                    state_next      = S_ACC;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_B_RD;
                end
            end
            S_ACC:
            begin
                mac_ctrl.acc_en = 1'b1;
                k_next          = k_reg + 1'b1;
                state_next      = S_KCHK;
            end
            // position finished
            S_PEND:
            begin
                cur_col_next = cur_col_reg + 1'b1;
                if (acc != '0)
                begin
                    rsp_valid_next    = 1'b1;
                    rsp_row_next      = IDX_W'(cur_row_reg);
                    rsp_col_next      = IDX_W'(cur_col_reg);
                    rsp_val_next      = acc;
                    rsp_flags_next[3] = 1'b1;
                    state_next        = S_IDLE;
                end
                else
                begin
                    state_next = S_POS;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            a_cnt_reg     <= '0;
            b_cnt_reg     <= '0;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_flags_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            a_cnt_reg     <= a_cnt_next;
            b_cnt_reg     <= b_cnt_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_flags_reg <= rsp_flags_next;
        end
    end

    // scan payload
    always_ff @(posedge clk)
    begin
        k_reg       <= k_next;
        idx_reg     <= idx_next;
        av_reg      <= av_next;
        rsp_row_reg <= rsp_row_next;
        rsp_col_reg <= rsp_col_next;
        rsp_val_reg <= rsp_val_next;
    end

    // response port
    assign rsp.valid          = rsp_valid_reg;
    assign rsp.out_row        = rsp_row_reg;
    assign rsp.out_col        = rsp_col_reg;
    assign rsp.out_value      = rsp_val_reg;
    assign rsp.found          = rsp_flags_reg[3];
    assign rsp.done_res       = rsp_flags_reg[2];
    assign rsp.size_mismatch  = rsp_flags_reg[1];
    assign rsp.table_overflow = rsp_flags_reg[0];

    // checks
    a_no_take_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> !rsp_valid_reg)
        else $error("item taken while a result is pending");

    a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> $onehot0(rsp_flags_reg))
        else $error("more than one result flag");

    a_found_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_flags_reg[3]) |-> (rsp_val_reg != '0))
        else $error("found result with zero value");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (a_cnt_reg <= CNT_W'(MAX_TERMS)) && (b_cnt_reg <= CNT_W'(MAX_TERMS)))
        else $error("table count beyond capacity");
endmodule
`default_nettype wire

/* src/stmm_ram.sv */
// stmm_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none
module stmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* src/stmm_mac.sv */
// stmm_mac: shared multiply-accumulate unit, product registered before the add
// depends on stmm_pkg
`default_nettype none
module stmm_mac (
    input  wire logic                        clk,
    input  wire stmm_pkg::mac_ctrl_t         ctrl,
    input  wire logic [stmm_pkg::VAL_W-1:0]  a,
    input  wire logic [stmm_pkg::VAL_W-1:0]  b,
    output logic      [stmm_pkg::VAL_W-1:0]  acc
);
    import stmm_pkg::*;

    logic [VAL_W-1:0] prod_reg;
    logic [VAL_W-1:0] acc_reg;
    logic [VAL_W-1:0] prod_next;

    // low word of the product, wraps at 32 bits
    assign prod_next = VAL_W'(a * b);

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (ctrl.clear)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.acc_en)
        begin
            acc_reg <= acc_reg + prod_reg;
        end
    end

    assign acc = acc_reg;
endmodule
`default_nettype wire
